// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared types, codes and defaults for the hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int KEY_BITS    = 64;
    localparam int DIGIT_BITS  = 8;
    localparam int HOME_STEPS  = KEY_BITS / DIGIT_BITS;
    localparam int HOME_STEP_W = $clog2(HOME_STEPS);

    localparam int COUNT_BITS = 9;
    localparam logic [COUNT_BITS-1:0] LOAD_LIMIT_RESET = 9'd180;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADKEY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_HOME,
        ENG_PROBE,
        ENG_RESP
    } eng_state_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [KEY_BITS-1:0] item_key;
        logic [31:0]         item_value;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [31:0]           found_value;
        logic [COUNT_BITS-1:0] entry_count_out;
    } out_item_t;

    typedef struct packed {
        logic used;
        logic tomb;
    } slot_flags_t;

    typedef struct packed {
        logic rd_en;
        logic flag_we;
        logic entry_we;
    } mem_ctrl_t;

endpackage

// ===== rtl/core/lpht_home.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Home slot unit
// Computes key modulo the slot count. A power-of-two table takes the low
// key bits; any other size reduces the key one byte per cycle.
// ----------------------------------------------------------------------------
module lpht_home #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lpht_pkg::KEY_BITS-1:0] key,
    output logic [$clog2(TABLE_SLOTS)-1:0] home_idx,
    output logic                          done
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    generate
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
            logic [IDX_W-1:0] home_reg;
            logic             done_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    home_reg <= key[IDX_W-1:0];
                end
            end

            assign home_idx = home_reg;
            assign done     = done_reg;
        end else begin : g_divide
            localparam logic [IDX_W:0] SLOTS_V = (IDX_W + 1)'(TABLE_SLOTS);
            localparam logic [lpht_pkg::HOME_STEP_W-1:0] LAST_STEP =
                lpht_pkg::HOME_STEP_W'(lpht_pkg::HOME_STEPS - 1);

            logic [IDX_W-1:0]                   rem_reg;
            logic [IDX_W-1:0]                   rem_next;
            logic [lpht_pkg::KEY_BITS-1:0]      shift_reg;
            logic [lpht_pkg::HOME_STEP_W-1:0]   step_reg;
            logic                               busy_reg;
            logic                               done_reg;
            logic [IDX_W:0]                     trial;

            // Restoring reduction over the top byte of the remaining key.
            always_comb begin
                rem_next = rem_reg;
                trial    = '0;
                for (int b = lpht_pkg::DIGIT_BITS - 1; b >= 0; b--) begin
                    trial = {rem_next, shift_reg[lpht_pkg::KEY_BITS - lpht_pkg::DIGIT_BITS + b]};
                    if (trial >= SLOTS_V) begin
                        trial = trial - SLOTS_V;
                    end
                    rem_next = trial[IDX_W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= 1'b0;
                    if (start) begin
                        busy_reg <= 1'b1;
                    end else if (busy_reg && step_reg == LAST_STEP) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    rem_reg   <= '0;
                    shift_reg <= key;
                    step_reg  <= '0;
                end else if (busy_reg) begin
                    rem_reg   <= rem_next;
                    shift_reg <= shift_reg << lpht_pkg::DIGIT_BITS;
                    step_reg  <= step_reg + 1'b1;
                end
            end

            assign home_idx = rem_reg;
            assign done     = done_reg;
        end
    endgenerate

endmodule

// ===== rtl/core/lpht_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot store
// Flag memory and entry memory, one read and one write port each, with
// registered read data. Sweeps the flag memory clear after reset.
// ----------------------------------------------------------------------------
module lpht_store #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lpht_pkg::mem_ctrl_t            ctrl,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    input  lpht_pkg::slot_flags_t          wr_flags,
    input  logic [lpht_pkg::KEY_BITS-1:0]  wr_key,
    input  logic [VALUE_BITS-1:0]          wr_value,
    output lpht_pkg::slot_flags_t          rd_flags,
    output logic [lpht_pkg::KEY_BITS-1:0]  rd_key,
    output logic [VALUE_BITS-1:0]          rd_value,
    output logic                           clearing
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    lpht_pkg::slot_flags_t         flag_mem  [TABLE_SLOTS];
    logic [lpht_pkg::KEY_BITS-1:0] key_mem   [TABLE_SLOTS];
    logic [VALUE_BITS-1:0]         value_mem [TABLE_SLOTS];

    lpht_pkg::slot_flags_t         rd_flags_reg;
    logic [lpht_pkg::KEY_BITS-1:0] rd_key_reg;
    logic [VALUE_BITS-1:0]         rd_value_reg;
    logic                          clr_active_reg;
    logic [IDX_W-1:0]              clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // The clearing pass owns the flag write port until it finishes.
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            flag_mem[clr_idx_reg] <= '0;
        end else if (ctrl.flag_we) begin
            flag_mem[wr_addr] <= wr_flags;
        end
        if (ctrl.rd_en) begin
            rd_flags_reg <= flag_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.entry_we) begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
        if (ctrl.rd_en) begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= value_mem[rd_addr];
        end
    end

    assign rd_flags = rd_flags_reg;
    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;
    assign clearing = clr_active_reg;

endmodule

// ===== rtl/core/lpht_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probe engine
// Sequences one operation at a time: home slot, linear probe through the
// slot store one slot per cycle, write back, and result.
// ----------------------------------------------------------------------------
module lpht_engine #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lpht_pkg::in_item_t                  in_item,
    input  logic [lpht_pkg::COUNT_BITS-1:0]     load_limit,
    input  logic                                clearing,
    output logic                                home_start,
    input  logic [$clog2(TABLE_SLOTS)-1:0]      home_idx,
    input  logic                                home_done,
    output lpht_pkg::mem_ctrl_t                 ctrl,
    output logic [$clog2(TABLE_SLOTS)-1:0]      rd_addr,
    output logic [$clog2(TABLE_SLOTS)-1:0]      wr_addr,
    output lpht_pkg::slot_flags_t               wr_flags,
    output logic [lpht_pkg::KEY_BITS-1:0]       wr_key,
    output logic [VALUE_BITS-1:0]               wr_value,
    input  lpht_pkg::slot_flags_t               rd_flags,
    input  logic [lpht_pkg::KEY_BITS-1:0]       rd_key,
    input  logic [VALUE_BITS-1:0]               rd_value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output lpht_pkg::out_item_t                 res_item
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    lpht_pkg::eng_state_t            state_reg;
    lpht_pkg::eng_state_t            state_next;
    logic [1:0]                      act_reg;
    logic [lpht_pkg::KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0]           val_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                n_reg;
    logic [lpht_pkg::COUNT_BITS-1:0] count_reg;
    lpht_pkg::status_t               status_reg;
    logic [31:0]                     found_reg;

    logic             accept;
    logic             bad_key;
    logic             limit_hit;
    logic             is_insert;
    logic             is_remove;
    logic             key_hit;
    logic             slot_free;
    logic             chain_end;
    logic             last_slot;
    logic             probe_done;
    logic [IDX_W-1:0] idx_step;

    assign accept    = in_valid && in_ready;
    assign bad_key   = (in_item.item_key == '0);
    assign limit_hit = (in_item.action == lpht_pkg::ACT_INSERT) && (count_reg >= load_limit);

    assign is_insert = (act_reg == lpht_pkg::ACT_INSERT);
    assign is_remove = (act_reg == lpht_pkg::ACT_REMOVE);
    // Keys of slots that were never written are only compared when used is set.
    assign key_hit   = rd_flags.used && (rd_key == key_reg);
    assign slot_free = !rd_flags.used;
    assign chain_end = !rd_flags.used && !rd_flags.tomb;
    assign last_slot = (n_reg == LAST_IDX);
    assign idx_step  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_comb begin
        if (is_insert) begin
            probe_done = slot_free || last_slot;
        end else begin
            probe_done = key_hit || chain_end || last_slot;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::ENG_IDLE: begin
                if (accept) begin
                    if (bad_key || limit_hit) begin
                        state_next = lpht_pkg::ENG_RESP;
                    end else begin
                        state_next = lpht_pkg::ENG_HOME;
                    end
                end
            end
            lpht_pkg::ENG_HOME: begin
                if (home_done) begin
                    state_next = lpht_pkg::ENG_PROBE;
                end
            end
            lpht_pkg::ENG_PROBE: begin
                if (probe_done) begin
                    state_next = lpht_pkg::ENG_RESP;
                end
            end
            lpht_pkg::ENG_RESP: begin
                if (res_ready) begin
                    state_next = lpht_pkg::ENG_IDLE;
                end
            end
            default: state_next = lpht_pkg::ENG_IDLE;
        endcase
    end

    // The write back happens in the last probe cycle, with no read in flight,
    // and the next operation cannot read before that write has landed.
    always_comb begin
        in_ready      = 1'b0;
        home_start    = 1'b0;
        ctrl          = '0;
        rd_addr       = idx_step;
        wr_addr       = idx_reg;
        wr_flags      = '0;
        wr_key        = key_reg;
        wr_value      = val_reg;
        res_valid     = 1'b0;
        unique case (state_reg)
            lpht_pkg::ENG_IDLE: begin
                in_ready   = !clearing;
                home_start = accept && !bad_key && !limit_hit;
            end
            lpht_pkg::ENG_HOME: begin
                rd_addr    = home_idx;
                ctrl.rd_en = home_done;
            end
            lpht_pkg::ENG_PROBE: begin
                ctrl.rd_en = !probe_done;
                if (probe_done && is_insert && slot_free) begin
                    ctrl.flag_we  = 1'b1;
                    ctrl.entry_we = 1'b1;
                    wr_flags.used = 1'b1;
                end else if (probe_done && is_remove && key_hit) begin
                    ctrl.flag_we  = 1'b1;
                    wr_flags.tomb = 1'b1;
                end
            end
            lpht_pkg::ENG_RESP: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpht_pkg::ENG_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lpht_pkg::ENG_PROBE && probe_done) begin
                if (is_insert && slot_free) begin
                    count_reg <= count_reg + 1'b1;
                end else if (is_remove && key_hit && count_reg != '0) begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lpht_pkg::ENG_IDLE: begin
                if (accept) begin
                    act_reg   <= in_item.action;
                    key_reg   <= in_item.item_key;
                    val_reg   <= VALUE_BITS'(in_item.item_value);
                    found_reg <= '0;
                    if (bad_key) begin
                        status_reg <= lpht_pkg::ST_BADKEY;
                    end else begin
                        status_reg <= lpht_pkg::ST_FULL;
                    end
                end
            end
            lpht_pkg::ENG_HOME: begin
                idx_reg <= home_idx;
                n_reg   <= '0;
            end
            lpht_pkg::ENG_PROBE: begin
                if (!probe_done) begin
                    idx_reg <= idx_step;
                    n_reg   <= n_reg + 1'b1;
                end else if (is_insert) begin
                    status_reg <= slot_free ? lpht_pkg::ST_OK : lpht_pkg::ST_FULL;
                end else if (key_hit) begin
                    status_reg <= lpht_pkg::ST_OK;
                    found_reg  <= 32'(rd_value);
                end else begin
                    status_reg <= lpht_pkg::ST_MISS;
                end
            end
            lpht_pkg::ENG_RESP: begin
                found_reg <= found_reg;
            end
            default: begin
                found_reg <= found_reg;
            end
        endcase
    end

    assign res_item.status          = status_reg;
    assign res_item.found_value     = found_reg;
    assign res_item.entry_count_out = count_reg;

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing table with linear probing and tombstones, keyed by a
// 64-bit id. Holds the load limit register and the result register.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                           Carries
//  -------   -----------------------------   ---------------------------------
//  input     s_valid, s_ready, s_item        action, item_key, item_value
//  result    m_valid, m_ready, m_item        status, found_value, entry_count_out
//  config    cfg_valid, cfg_ready, cfg_data  load_limit
//
//  One operation at a time. A probe reads from 1 to TABLE_SLOTS slots, and
//  the slot store reads one slot per cycle. After reset a clearing pass over
//  every slot holds s_ready low; configuration transfers are taken throughout.
//  A stalled result waits in the output register and the next operation can
//  be accepted meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lpht_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lpht_pkg::out_item_t             m_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpht_pkg::COUNT_BITS-1:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic [lpht_pkg::COUNT_BITS-1:0] load_limit_reg;
    logic                            m_valid_reg;
    lpht_pkg::out_item_t             m_item_reg;

    logic                            clearing;
    logic                            home_start;
    logic [IDX_W-1:0]                home_idx;
    logic                            home_done;
    lpht_pkg::mem_ctrl_t             ctrl;
    logic [IDX_W-1:0]                rd_addr;
    logic [IDX_W-1:0]                wr_addr;
    lpht_pkg::slot_flags_t           wr_flags;
    logic [lpht_pkg::KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0]           wr_value;
    lpht_pkg::slot_flags_t           rd_flags;
    logic [lpht_pkg::KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0]           rd_value;
    logic                            res_valid;
    logic                            res_ready;
    lpht_pkg::out_item_t             res_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_limit_reg <= lpht_pkg::LOAD_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            load_limit_reg <= cfg_data;
        end
    end

    // The output register frees up in the same cycle that its result transfers.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    lpht_home #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_home (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (home_start),
        .key      (s_item.item_key),
        .home_idx (home_idx),
        .done     (home_done)
    );

    lpht_store #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_flags (wr_flags),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_flags (rd_flags),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .clearing (clearing)
    );

    lpht_engine #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (s_item),
        .load_limit (load_limit_reg),
        .clearing   (clearing),
        .home_start (home_start),
        .home_idx   (home_idx),
        .home_done  (home_done),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_flags   (wr_flags),
        .wr_key     (wr_key),
        .wr_value   (wr_value),
        .rd_flags   (rd_flags),
        .rd_key     (rd_key),
        .rd_value   (rd_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives insert, remove and lookup operations into the hash table and checks
// every result against a local table that probes the same way. Runs a short
// directed sequence, then long random phases with several load limits,
// random idling on both channels and a long stall on the result channel.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS          = lpht_pkg::TABLE_SLOTS_DEF;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_REPORTS    = 50;

    // A two-bit action code outside the enum; the block treats it as a lookup.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    lpht_pkg::in_item_t              s_item    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    lpht_pkg::out_item_t             m_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lpht_pkg::COUNT_BITS-1:0] cfg_data  = '0;

    linear_probe_hash_table i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Operations waiting to be offered and results waiting to arrive.
    lpht_pkg::in_item_t  pending_ops[$];
    lpht_pkg::out_item_t pending_results[$];
    logic [63:0]         known_keys[$];

    // Local copy of the table.
    logic [63:0]                     slot_id[SLOTS];
    logic [31:0]                     slot_data[SLOTS];
    bit                              slot_live[SLOTS];
    bit                              slot_grave[SLOTS];
    int unsigned                     live_entries = 0;
    logic [lpht_pkg::COUNT_BITS-1:0] limit_model  = lpht_pkg::LOAD_LIMIT_RESET;

    bit          s_taken        = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned rx_idle_pct    = 0;
    int unsigned rx_hold_left   = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_served   = 0;
    int unsigned limit_writes   = 0;
    int unsigned ops_accepted   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned action_seen[4];
    int unsigned status_seen[4];

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("Run timed out with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Applies one operation to the local table and returns the result it causes.
    function automatic lpht_pkg::out_item_t apply_op(input lpht_pkg::in_item_t op);
        lpht_pkg::out_item_t res;
        int unsigned         idx;
        int                  hit;
        res.status      = lpht_pkg::ST_OK;
        res.found_value = '0;
        idx = int'(op.item_key % SLOTS);
        hit = -1;
        action_seen[op.action]++;
        if (op.item_key == '0) begin
            res.status = lpht_pkg::ST_BADKEY;
        end else if (op.action == lpht_pkg::ACT_INSERT) begin
            res.status = lpht_pkg::ST_FULL;
            if (live_entries < limit_model) begin
                // A tombstone counts as free, so only the used flag matters here.
                for (int n = 0; n < SLOTS; n++) begin
                    if (!slot_live[idx]) begin
                        slot_live[idx]  = 1'b1;
                        slot_grave[idx] = 1'b0;
                        slot_id[idx]    = op.item_key;
                        slot_data[idx]  = op.item_value;
                        live_entries++;
                        res.status = lpht_pkg::ST_OK;
                        break;
                    end
                    idx = (idx + 1) % SLOTS;
                end
            end
        end else begin
            for (int n = 0; n < SLOTS; n++) begin
                if (slot_live[idx]) begin
                    if (slot_id[idx] == op.item_key) begin
                        hit = idx;
                        break;
                    end
                end else if (!slot_grave[idx]) begin
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
            if (hit < 0) begin
                res.status = lpht_pkg::ST_MISS;
            end else begin
                res.found_value = slot_data[hit];
                if (op.action == lpht_pkg::ACT_REMOVE) begin
                    slot_live[hit]  = 1'b0;
                    slot_grave[hit] = 1'b1;
                    if (live_entries > 0) live_entries--;
                end
            end
        end
        res.entry_count_out = live_entries[lpht_pkg::COUNT_BITS-1:0];
        status_seen[res.status]++;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("Mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
        end
    endtask

    // Monitor: everything is sampled at the rising edge.
    always @(posedge aclk) begin : monitor
        lpht_pkg::out_item_t want;
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                limit_model = cfg_data;
                limit_writes++;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, status", m_item.status, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_item.status !== want.status)
                        report_mismatch("status", m_item.status, want.status);
                    if (m_item.found_value !== want.found_value)
                        report_mismatch("found_value", m_item.found_value, want.found_value);
                    if (m_item.entry_count_out !== want.entry_count_out)
                        report_mismatch("entry_count_out", m_item.entry_count_out,
                                        want.entry_count_out);
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_op(s_item));
                ops_accepted++;
            end
        end
    end

    // Driver: a new operation goes out only once the previous transfer is done.
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !s_taken)) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_item  <= pending_ops.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (holds_served != holds_asked) begin
            rx_hold_left <= RX_HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && rx_hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
    end

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_valid || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_load_limit(input logic [lpht_pkg::COUNT_BITS-1:0] limit);
        int unsigned seen;
        seen = limit_writes;
        @(negedge aclk);
        cfg_data  <= limit;
        cfg_valid <= 1'b1;
        while (limit_writes == seen) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_op(input logic [1:0] act, input logic [63:0] key,
                            input logic [31:0] val);
        lpht_pkg::in_item_t op;
        op.action     = act;
        op.item_key   = key;
        op.item_value = val;
        pending_ops.push_back(op);
    endtask

    // Half of the keys land in a narrow band of home slots that wraps past the
    // end of the table, so probe chains grow long and cross the wrap.
    function automatic logic [63:0] random_key();
        logic [63:0] key;
        key = {$urandom, $urandom};
        if ($urandom_range(1) == 0) key[7:0] = 8'(248 + $urandom_range(15));
        return key;
    endfunction

    task automatic queue_random_op(input int unsigned insert_pct);
        logic [63:0] key;
        logic [1:0]  act;
        int unsigned pick;
        key = random_key();
        if ($urandom_range(99) < insert_pct) begin
            act = lpht_pkg::ACT_INSERT;
            if (known_keys.size() != 0 && $urandom_range(19) == 0) begin
                key = known_keys[$urandom_range(known_keys.size() - 1)];
            end else begin
                known_keys.push_back(key);
                if (known_keys.size() > 512) void'(known_keys.pop_front());
            end
        end else begin
            act = ($urandom_range(1) == 0) ? lpht_pkg::ACT_REMOVE : lpht_pkg::ACT_LOOKUP;
            if ($urandom_range(49) == 0) act = ACT_SPARE;
            if (known_keys.size() != 0 && $urandom_range(3) != 0) begin
                pick = $urandom_range(known_keys.size() - 1);
                key  = known_keys[pick];
                if (act == lpht_pkg::ACT_REMOVE && $urandom_range(1) == 0) begin
                    known_keys.delete(pick);
                end
            end
        end
        if ($urandom_range(49) == 0) key = '0;
        queue_op(act, key, $urandom);
    endtask

    task automatic queue_random_ops(input int unsigned count, input int unsigned insert_pct);
        repeat (count) queue_random_op(insert_pct);
    endtask

    initial begin
        send_idle_pct = 9;
        rx_idle_pct   = 65;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // A limit of one admits a single entry at a time.
        set_load_limit(9'd1);
        queue_op(lpht_pkg::ACT_INSERT, 64'h1, 32'h0000_1111);
        queue_op(lpht_pkg::ACT_INSERT, 64'h2, 32'h0000_2222);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'h1, 32'h0);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h1, 32'h0);
        queue_op(lpht_pkg::ACT_INSERT, 64'h2, 32'h0000_2222);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h2, 32'h0);
        wait_drained();

        // A limit of zero refuses every insert.
        set_load_limit(9'd0);
        queue_op(lpht_pkg::ACT_INSERT, 64'h3, 32'h0000_3333);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'h3, 32'h0);
        wait_drained();

        set_load_limit(lpht_pkg::LOAD_LIMIT_RESET);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'h55, 32'h0);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h55, 32'h0);
        queue_op(lpht_pkg::ACT_INSERT, 64'h0, 32'hDEAD_BEEF);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h0, 32'h0);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'h0, 32'h0);
        queue_op(lpht_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        // Home slot of the last slot is taken, so this one wraps to slot zero.
        queue_op(lpht_pkg::ACT_INSERT, 64'h1FF, 32'h1);
        queue_op(lpht_pkg::ACT_INSERT, 64'h100, 32'h2);
        queue_op(lpht_pkg::ACT_INSERT, 64'h100, 32'h3);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'h100, 32'h0);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h100, 32'h0);
        // The second copy sits behind the tombstone left by the remove.
        queue_op(lpht_pkg::ACT_LOOKUP, 64'h100, 32'h0);
        queue_op(ACT_SPARE, 64'h1FF, 32'h0);
        queue_op(lpht_pkg::ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_op(lpht_pkg::ACT_INSERT, 64'hAAAA_AAAA_AAAA_AA00, 32'h5555_5555);
        queue_op(lpht_pkg::ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_AA00, 32'h0);
        queue_op(lpht_pkg::ACT_INSERT, 64'h8000_0000_0000_00FF, 32'h0);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h100, 32'h0);
        queue_op(lpht_pkg::ACT_REMOVE, 64'h100, 32'h0);
        wait_drained();

        // Random phase with a long result stall while the sender keeps offering.
        queue_random_ops(500, 55);
        holds_asked++;
        wait_drained();

        // Fill the whole table, so probes run full passes through tombstones.
        send_idle_pct = 65;
        rx_idle_pct   = 9;
        set_load_limit(9'd256);
        queue_random_ops(300, 80);
        wait_drained();
        queue_random_ops(300, 80);
        wait_drained();

        send_idle_pct = 0;
        rx_idle_pct   = 0;
        set_load_limit(9'($urandom_range(2, 255)));
        queue_random_ops(400, 45);
        wait_drained();

        set_load_limit(9'd40);
        queue_random_ops(500, 50);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d results for %0d operations: %0d inserts, %0d removes, %0d lookups",
                 results_checked, ops_accepted, action_seen[lpht_pkg::ACT_INSERT],
                 action_seen[lpht_pkg::ACT_REMOVE],
                 action_seen[lpht_pkg::ACT_LOOKUP] + action_seen[ACT_SPARE]);
        $display("Status mix: %0d ok, %0d miss, %0d full, %0d bad key; %0d limit writes",
                 status_seen[lpht_pkg::ST_OK], status_seen[lpht_pkg::ST_MISS],
                 status_seen[lpht_pkg::ST_FULL], status_seen[lpht_pkg::ST_BADKEY],
                 limit_writes);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_home.sv
rtl/core/lpht_store.sv
rtl/core/lpht_engine.sv
rtl/core/linear_probe_hash_table.sv
test/testbench.sv
